[src/u8sd_pkg.sv]
package u8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned RemW   = 3;
  localparam int unsigned OnesW  = 4;
  localparam int unsigned PayW   = 6;   // payload bits of a continuation byte

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_marker;
  } in_beat_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic [1:0]     status;
  } out_beat_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [CpW-1:0]  acc;
  } dec_state_t;

  // count of leading ones, 0..8
  function automatic logic [OnesW-1:0] lead_ones(input logic [ByteW-1:0] b);
    logic [OnesW-1:0] n;
    logic             run;
    n   = '0;
    run = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      run = run & b[i];
      n   = n + {{(OnesW-1){1'b0}}, run};
    end
    return n;
  endfunction

endpackage

[src/u8sd_stream_if.sv]
interface u8sd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/utf8_stream_decoder_unit.sv]
// channel | dir | payload                          | handshake
// in_i    | in  | data_byte[7:0], end_marker       | valid/ready
// out_o   | out | code_point[30:0], status[1:0]    | valid/ready
//
// One byte beat per cycle while in_i is not stalled; a result is registered into
// the output buffer. The decode is a leading-ones count, a mask and a 6-bit shift
// into the accumulator, all combinational ahead of the output register.
// A two-entry output buffer holds ready high while one result waits; in_i stalls
// only when both entries are full. Reset (async, active low) clears the
// sequence state and empties the output buffer.
module utf8_stream_decoder_unit
  import u8sd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  u8sd_stream_if.sink   in_i,
  u8sd_stream_if.source out_o
);

  dec_state_t state_q, state_d;
  logic       res_valid;
  out_beat_t  res;
  logic       space;
  logic       in_acc;

  assign in_i.ready = space;
  assign in_acc     = in_i.valid & space;

  u8sd_step u_step (
    .beat_i      (in_i.payload),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  u8sd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc & res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_o       (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no result pending");

  a_err_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.status != ST_OK) |-> out_o.payload.code_point == '0)
    else $error("error beat carries a non-zero code point");

  a_idle_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.rem == '0 |-> state_q.acc == '0)
    else $error("accumulator not clear while idle");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.payload.end_marker) |=> state_q.rem == '0)
    else $error("end marker did not return decoder to idle");

endmodule

[src/u8sd_step.sv]
module u8sd_step
  import u8sd_pkg::*;
(
  input  in_beat_t   beat_i,
  input  dec_state_t state_i,
  output dec_state_t state_o,
  output logic       res_valid_o,
  output out_beat_t  res_o
);

  logic [OnesW-1:0] ones;
  logic [ByteW-1:0] lead_bits;
  logic [CpW-1:0]   acc_shift;

  assign ones      = lead_ones(beat_i.data_byte);
  assign lead_bits = beat_i.data_byte & (8'h7f >> ones);
  assign acc_shift = {state_i.acc[CpW-PayW-1:0], beat_i.data_byte[PayW-1:0]};

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{code_point: '0, status: ST_OK};

    if (beat_i.end_marker) begin
      if (state_i.rem != '0) begin
        state_o     = '0;
        res_valid_o = 1'b1;
        res_o.status = ST_TRUNC;
      end
    end else if (state_i.rem == '0) begin
      if (ones == 4'd0) begin
        res_valid_o      = 1'b1;
        res_o.code_point = {{(CpW-ByteW){1'b0}}, beat_i.data_byte};
      end else if (ones == 4'd1 || ones > 4'd6) begin
        state_o      = '0;
        res_valid_o  = 1'b1;
        res_o.status = ST_BAD_LEAD;
      end else begin
        state_o.acc = {{(CpW-ByteW){1'b0}}, lead_bits};
        state_o.rem = ones[RemW-1:0] - 3'd1;
      end
    end else if (ones != 4'd1) begin
      // bad continuation is swallowed, not re-read as a lead
      state_o      = '0;
      res_valid_o  = 1'b1;
      res_o.status = ST_BAD_CONT;
    end else if (state_i.rem == 3'd1) begin
      state_o          = '0;
      res_valid_o      = 1'b1;
      res_o.code_point = acc_shift;
    end else begin
      state_o.acc = acc_shift;
      state_o.rem = state_i.rem - 3'd1;
    end
  end

endmodule

[src/u8sd_out_buf.sv]
module u8sd_out_buf
  import u8sd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_beat_t push_data_i,
  output logic      space_o,
  u8sd_stream_if.source out_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_beat_t out_q, out_d;
  out_beat_t skid_q, skid_d;
  logic      pop;

  assign pop     = out_valid_q & out_o.ready;
  assign space_o = ~skid_valid_q;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (!out_valid_q) begin
      out_valid_d = push_i;
      out_d       = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

[tb/utf8_stream_decoder_unit_test.sv]
`timescale 1ns / 100ps

module utf8_stream_decoder_unit_test;
  import u8sd_pkg::*;

  localparam int unsigned RandBytes = 700;
  localparam int unsigned IdleLimit = 400;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    bit        has;
    out_beat_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  u8sd_stream_if #(.payload_t(in_beat_t))  byte_ch ();
  u8sd_stream_if #(.payload_t(out_beat_t)) cp_ch ();

  utf8_stream_decoder_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (cp_ch)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // decoder state as the block should hold it
  logic [RemW-1:0] dec_rem = '0;
  logic [CpW-1:0]  dec_acc = '0;

  out_beat_t   expected_cps[$];
  dir_row_t    dir_rows[$];
  int unsigned fail_count;
  int unsigned bytes_taken;
  int unsigned cps_checked;
  int unsigned status_seen[4];
  int unsigned idle_cycles;
  int unsigned burst_left;

  // typed-in expectation travelling with the beat on the wire
  bit        wire_typed;
  bit        wire_has;
  out_beat_t wire_want;

  out_beat_t pred;
  out_beat_t want;
  bit        pred_has;

  function automatic bit decode_byte(input in_beat_t beat, output out_beat_t res);
    logic [3:0] n;
    logic [7:0] b;
    logic [7:0] mask;
    res = '0;
    b   = beat.data_byte;
    if (beat.end_marker) begin
      if (dec_rem != '0) begin
        dec_rem    = '0;
        dec_acc    = '0;
        res.status = ST_TRUNC;
        return 1'b1;
      end
      return 1'b0;
    end
    casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    if (dec_rem == '0) begin
      if (n == 4'd0) begin
        res.code_point = {{(CpW-ByteW){1'b0}}, b};
        return 1'b1;
      end
      if (n == 4'd1 || n > 4'd6) begin
        dec_acc    = '0;
        res.status = ST_BAD_LEAD;
        return 1'b1;
      end
      mask    = (8'd1 << (3'd7 - n[2:0])) - 8'd1;
      dec_acc = {{(CpW-ByteW){1'b0}}, b & mask};
      dec_rem = n[2:0] - 3'd1;
      return 1'b0;
    end
    // mid-sequence: anything but 10xxxxxx is eaten and aborts
    if (n != 4'd1) begin
      dec_rem    = '0;
      dec_acc    = '0;
      res.status = ST_BAD_CONT;
      return 1'b1;
    end
    dec_acc = {dec_acc[CpW-7:0], b[5:0]};
    dec_rem = dec_rem - 3'd1;
    if (dec_rem == '0) begin
      res.code_point = dec_acc;
      dec_acc        = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic tab_row(input logic [7:0] b, input bit e, input bit typed, input bit has,
                         input logic [CpW-1:0] cp, input status_e st);
    dir_row_t r;
    r.beat.data_byte  = b;
    r.beat.end_marker = e;
    r.typed           = typed;
    r.has             = has;
    r.want.code_point = cp;
    r.want.status     = st;
    dir_rows.push_back(r);
  endtask

  task automatic send_beat(input in_beat_t beat, input bit typed, input bit has,
                           input out_beat_t exp_res);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        byte_ch.valid   <= 1'b0;
        byte_ch.payload <= in_beat_t'($urandom);
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk_i);
    wire_typed = typed;
    wire_has   = has;
    wire_want  = exp_res;
    byte_ch.valid   <= 1'b1;
    byte_ch.payload <= beat;
    do @(posedge clk_i); while (!(byte_ch.valid && byte_ch.ready));
  endtask

  // receiver: ready pattern switches between four styles picked at random
  int unsigned rx_cycle;
  int unsigned rx_mode;
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: cp_ch.ready <= 1'b1;
      1: cp_ch.ready <= ($urandom_range(0, 3) != 0);
      2: cp_ch.ready <= (rx_cycle % 4 == 0);
      default: cp_ch.ready <= (rx_cycle % 16 >= 12);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cp_ch.valid && cp_ch.ready) begin
        status_seen[cp_ch.payload.status] = status_seen[cp_ch.payload.status] + 1;
        if (expected_cps.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: unexpected result cp %h status %0d", $time,
                   cp_ch.payload.code_point, cp_ch.payload.status);
        end else begin
          want        = expected_cps.pop_front();
          cps_checked = cps_checked + 1;
          if (cp_ch.payload.code_point !== want.code_point) begin
            fail_count = fail_count + 1;
            $display("%0t: code_point expected %h actual %h", $time,
                     want.code_point, cp_ch.payload.code_point);
          end
          if (cp_ch.payload.status !== want.status) begin
            fail_count = fail_count + 1;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, cp_ch.payload.status);
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_taken = bytes_taken + 1;
        pred_has    = decode_byte(byte_ch.payload, pred);
        if (wire_typed) begin
          if (wire_has) expected_cps.push_back(wire_want);
        end else if (pred_has) begin
          expected_cps.push_back(pred);
        end
      end
      if ((cp_ch.valid && cp_ch.ready) || (byte_ch.valid && byte_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_beat_t    beat;
    int unsigned len;
    int unsigned brk;
    int unsigned pick;
    int unsigned n_dir;
    logic [7:0]  b;

    byte_ch.valid   = 1'b0;
    byte_ch.payload = '0;
    rst_ni          = 1'b0;
    burst_left      = 0;
    wire_typed      = 1'b0;
    wire_has        = 1'b0;
    wire_want       = '0;

    // byte, end, typed, has, code point, status
    tab_row(8'h00, 1'b0, 1'b1, 1'b1, 31'h0,  ST_OK);
    tab_row(8'h7f, 1'b0, 1'b1, 1'b1, 31'h7f, ST_OK);
    tab_row(8'h80, 1'b0, 1'b1, 1'b1, 31'h0,  ST_BAD_LEAD);   // stray continuation
    tab_row(8'hfe, 1'b0, 1'b1, 1'b1, 31'h0,  ST_BAD_LEAD);
    tab_row(8'hff, 1'b0, 1'b1, 1'b1, 31'h0,  ST_BAD_LEAD);
    tab_row(8'ha5, 1'b1, 1'b1, 1'b0, 31'h0,  ST_OK);         // end while idle: nothing
    tab_row(8'hc3, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'ha9, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'hf0, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'h9f, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'h98, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'h80, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'hfd, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);         // six-byte form, all ones
    for (int i = 0; i < 4; i++) tab_row(8'hbf, 1'b0, 1'b0, 1'b0, 31'h0, ST_OK);
    tab_row(8'hbf, 1'b0, 1'b1, 1'b1, 31'h7fffffff, ST_OK);
    tab_row(8'he2, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'h41, 1'b0, 1'b1, 1'b1, 31'h0,  ST_BAD_CONT);   // ASCII mid-sequence
    tab_row(8'hc3, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'hc3, 1'b0, 1'b1, 1'b1, 31'h0,  ST_BAD_CONT);   // lead mid-sequence, eaten
    tab_row(8'ha9, 1'b0, 1'b1, 1'b1, 31'h0,  ST_BAD_LEAD);
    tab_row(8'hf8, 1'b0, 1'b0, 1'b0, 31'h0,  ST_OK);
    tab_row(8'hff, 1'b1, 1'b1, 1'b1, 31'h0,  ST_TRUNC);
    n_dir = dir_rows.size();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed,
                                    dir_rows[i].has, dir_rows[i].want);

    while (bytes_taken < n_dir + RandBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        // sequence of random length; some are cut short by an end or a bad byte
        len = $urandom_range(1, 6);
        brk = (pick >= 70 && len > 1) ? $urandom_range(1, len - 1) : 0;
        if (len == 1) b = 8'($urandom_range(0, 127));
        else b = (8'hff << (8 - len)) | (8'($urandom) & ((8'd1 << (7 - len)) - 8'd1));
        beat.data_byte  = b;
        beat.end_marker = 1'b0;
        send_beat(beat, 1'b0, 1'b0, '0);
        for (int k = 1; k < len; k++) begin
          beat.data_byte  = 8'h80 | (8'($urandom) & 8'h3f);
          beat.end_marker = 1'b0;
          if (k == brk) begin
            if ($urandom_range(0, 1) == 0) begin
              beat.data_byte  = 8'($urandom);
              beat.end_marker = 1'b1;
            end else begin
              b = 8'($urandom);
              if (b[7:6] == 2'b10) b[6] = 1'b1;
              beat.data_byte = b;
            end
          end
          send_beat(beat, 1'b0, 1'b0, '0);
          if (k == brk) break;
        end
      end else begin
        beat.data_byte  = 8'($urandom);
        beat.end_marker = ($urandom_range(0, 5) == 0);
        send_beat(beat, 1'b0, 1'b0, '0);
      end
    end
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;

    while (expected_cps.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Fed %0d bytes (%0d directed) incl. 2- to 6-byte, broken and truncated forms;",
             bytes_taken, n_dir);
    $display("checked %0d results: ok %0d, bad lead %0d, bad continuation %0d, truncated %0d",
             cps_checked, status_seen[ST_OK], status_seen[ST_BAD_LEAD],
             status_seen[ST_BAD_CONT], status_seen[ST_TRUNC]);
    if (fail_count == 0 && expected_cps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
